### hdl/tgme_pkg.sv
// Shared types and constants of the trap grid move engine.
// Used by tgme_regs, tgme_ctrl, tgme_dp and trap_grid_move_engine; depends on nothing.
package tgme_pkg;

  localparam int MAX_COLUMNS_DEF = 32;
  localparam int MAX_ROWS_DEF    = 32;

  // Width of index sums such as y_pos + run_length, with room for 64-entry grids.
  localparam int IDX_W  = 7;
  localparam int CFG_W  = 6;
  localparam int ADDR_W = 3;

  localparam logic [CFG_W-1:0] GRID_COLUMNS_RST = 6'd32;
  localparam logic [CFG_W-1:0] GRID_ROWS_RST    = 6'd32;

  localparam logic REG_GRID_COLUMNS = 1'b0;
  localparam logic REG_GRID_ROWS    = 1'b1;

  localparam logic [3:0] REQ_UP        = 4'd0;
  localparam logic [3:0] REQ_DOWN      = 4'd1;
  localparam logic [3:0] REQ_RIGHT     = 4'd2;
  localparam logic [3:0] REQ_LEFT      = 4'd3;
  localparam logic [3:0] REQ_EXTRACT_X = 4'd4;
  localparam logic [3:0] REQ_IMPLANT_X = 4'd5;
  localparam logic [3:0] REQ_EXTRACT_Y = 4'd6;
  localparam logic [3:0] REQ_IMPLANT_Y = 4'd7;
  localparam logic [3:0] REQ_LOAD      = 4'd8;
  localparam logic [3:0] REQ_CLEAR     = 4'd9;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_COLLISION = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_LOAD_A,
    S_LOAD_B,
    S_OPERATE,
    S_WRITE_A,
    S_WRITE_B,
    S_FINAL_RD,
    S_FINAL_WAIT
  } state_t;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_NEXT,
    RD_REQ
  } rdsel_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_SHIFT,
    K_PAIR,
    K_COLUMN,
    K_XRUN
  } kind_t;

  typedef struct packed {
    logic   accept;
    logic   init;
    logic   rd_en;
    rdsel_t rd_sel;
    logic   load_a;
    logic   load_b;
    logic   step;
    logic   wr_a;
    logic   wr_b;
    logic   next_col;
    logic   finish;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  shift_done;
    logic  xrun_last;
  } stat_t;

endpackage

### hdl/tgme_regs.sv
// Configuration registers (grid_columns, grid_rows) behind the APB-style port.
// Depends on tgme_pkg.
module tgme_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tgme_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [tgme_pkg::CFG_W-1:0]  grid_columns,
  output logic [tgme_pkg::CFG_W-1:0]  grid_rows
);

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[tgme_pkg::ADDR_W-1];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= tgme_pkg::GRID_COLUMNS_RST;
      grid_rows    <= tgme_pkg::GRID_ROWS_RST;
    end else if (wr_en) begin
      if (reg_index == tgme_pkg::REG_GRID_ROWS) begin
        grid_rows <= pwdata[tgme_pkg::CFG_W-1:0];
      end else begin
        grid_columns <= pwdata[tgme_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_index == tgme_pkg::REG_GRID_ROWS) begin
      prdata = 32'(grid_rows);
    end else begin
      prdata = 32'(grid_columns);
    end
  end

endmodule

### hdl/tgme_ctrl.sv
// Sequencer of the move engine: walks each request with column work through read, operate and write-back.
// Depends on tgme_pkg; drives tgme_dp through cmd_t and observes stat_t.
module tgme_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tgme_pkg::stat_t stat,
  output tgme_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  tgme_pkg::state_t state;
  tgme_pkg::state_t state_next;
  logic             done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgme_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != tgme_pkg::S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    done_next  = 1'b0;
    case (state)
      tgme_pkg::S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = tgme_pkg::S_DECODE;
        end
      end
      tgme_pkg::S_DECODE: begin
        cmd.init = 1'b1;
        if (stat.kind == tgme_pkg::K_NONE) begin
          state_next = tgme_pkg::S_FINAL_RD;
        end else begin
          state_next = tgme_pkg::S_READ;
        end
      end
      tgme_pkg::S_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tgme_pkg::RD_CUR;
        state_next = tgme_pkg::S_LOAD_A;
      end
      tgme_pkg::S_LOAD_A: begin
        cmd.load_a = 1'b1;
        if (stat.kind == tgme_pkg::K_PAIR) begin
          // The neighbor column is fetched while the first one is captured.
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = tgme_pkg::RD_NEXT;
          state_next = tgme_pkg::S_LOAD_B;
        end else begin
          state_next = tgme_pkg::S_OPERATE;
        end
      end
      tgme_pkg::S_LOAD_B: begin
        cmd.load_b = 1'b1;
        state_next = tgme_pkg::S_OPERATE;
      end
      tgme_pkg::S_OPERATE: begin
        if (stat.kind == tgme_pkg::K_SHIFT) begin
          if (stat.shift_done) begin
            state_next = tgme_pkg::S_WRITE_A;
          end else begin
            cmd.step = 1'b1;
          end
        end else begin
          cmd.step   = 1'b1;
          state_next = tgme_pkg::S_WRITE_A;
        end
      end
      tgme_pkg::S_WRITE_A: begin
        cmd.wr_a = 1'b1;
        if (stat.kind == tgme_pkg::K_PAIR) begin
          state_next = tgme_pkg::S_WRITE_B;
        end else if (stat.kind == tgme_pkg::K_XRUN) begin
          cmd.next_col = 1'b1;
          state_next   = stat.xrun_last ? tgme_pkg::S_FINAL_RD : tgme_pkg::S_READ;
        end else begin
          state_next = tgme_pkg::S_FINAL_RD;
        end
      end
      tgme_pkg::S_WRITE_B: begin
        cmd.wr_b   = 1'b1;
        state_next = tgme_pkg::S_FINAL_RD;
      end
      tgme_pkg::S_FINAL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tgme_pkg::RD_REQ;
        state_next = tgme_pkg::S_FINAL_WAIT;
      end
      tgme_pkg::S_FINAL_WAIT: begin
        cmd.finish = 1'b1;
        done_next  = 1'b1;
        state_next = tgme_pkg::S_IDLE;
      end
      default: begin
        state_next = tgme_pkg::S_IDLE;
      end
    endcase
  end

  a_done_after_wait: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == tgme_pkg::S_FINAL_WAIT)
    else $error("result strobe without a finished request");

  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("block busy while its result is shown");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == tgme_pkg::S_DECODE)
    else $error("accepted request did not reach decode");

  a_shift_walk: assert property (@(posedge clk) disable iff (rst)
    (state == tgme_pkg::S_OPERATE && stat.kind == tgme_pkg::K_SHIFT && !stat.shift_done)
    |=> state == tgme_pkg::S_OPERATE)
    else $error("shift walk left before its last step");

endmodule

### hdl/tgme_dp.sv
// Datapath of the move engine: request registers, range check, column memories,
// working columns, move counter and result registers. Depends on tgme_pkg.
module tgme_dp #(
  parameter int MAX_COLUMNS = tgme_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tgme_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tgme_pkg::cmd_t             cmd,
  output tgme_pkg::stat_t            stat,
  input  logic [tgme_pkg::CFG_W-1:0] grid_columns,
  input  logic [tgme_pkg::CFG_W-1:0] grid_rows,
  input  logic [3:0]                 req_type,
  input  logic [4:0]                 x_pos,
  input  logic [4:0]                 y_pos,
  input  logic [5:0]                 run_length,
  input  logic [31:0]                load_bits,
  output logic [1:0]                 status,
  output logic [31:0]                column_occupancy,
  output logic [15:0]                moves_done
);

  localparam int AW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int IW = tgme_pkg::IDX_W;

  // Request registers.
  logic [3:0]  req_r;
  logic [4:0]  x_r;
  logic [4:0]  y_r;
  logic [5:0]  len_r;
  logic [31:0] bits_r;

  logic [IW-1:0] cx;
  logic [IW-1:0] p;
  logic [IW-1:0] rem;
  logic [1:0]    status_r;
  logic [15:0]   counter;

  logic [MAX_ROWS-1:0] wa, ma, wb, mb;
  logic [MAX_ROWS-1:0] wa_mv, ma_mv;

  logic [MAX_ROWS-1:0] occ_mem  [MAX_COLUMNS];
  logic [MAX_ROWS-1:0] mark_mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] col_valid;
  logic [MAX_ROWS-1:0] occ_rd, mark_rd;
  logic                rd_valid;

  logic [IW-1:0] xs, ys, ls, xs1, cols, rows, gc, gr, pd, ysum, xsum;
  logic          range_err;
  tgme_pkg::kind_t kind;
  logic [AW-1:0] cur_addr, next_addr, req_addr, rad, wad;
  logic          mem_we;
  logic [MAX_ROWS-1:0] wd_occ, wd_mark;
  logic [MAX_ROWS-1:0] rm, ymask, lb, occ_in, mark_in, yhit;
  logic [RW-1:0] s_idx, d_idx, y_idx;
  logic          up, xset, yset, x_in;
  logic [MAX_ROWS-1:0] col_masked;

  assign xs   = IW'(x_r);
  assign ys   = IW'(y_r);
  assign ls   = IW'(len_r);
  assign xs1  = xs + IW'(1);
  assign ysum = ys + ls;
  assign xsum = xs + ls;
  assign gc   = IW'(grid_columns);
  assign gr   = IW'(grid_rows);
  assign cols = (gc < IW'(MAX_COLUMNS)) ? gc : IW'(MAX_COLUMNS);
  assign rows = (gr < IW'(MAX_ROWS)) ? gr : IW'(MAX_ROWS);

  always_comb begin
    range_err = 1'b0;
    kind      = tgme_pkg::K_NONE;
    case (req_r)
      tgme_pkg::REQ_UP, tgme_pkg::REQ_DOWN: begin
        range_err = (xs >= cols) || (ysum >= rows);
        kind      = tgme_pkg::K_SHIFT;
      end
      tgme_pkg::REQ_RIGHT, tgme_pkg::REQ_LEFT: begin
        range_err = (xs1 >= cols) || (ys >= rows);
        kind      = tgme_pkg::K_PAIR;
      end
      tgme_pkg::REQ_EXTRACT_X, tgme_pkg::REQ_IMPLANT_X: begin
        range_err = (xsum > cols) || (ys >= rows);
        kind      = (len_r == 6'd0) ? tgme_pkg::K_NONE : tgme_pkg::K_XRUN;
      end
      tgme_pkg::REQ_EXTRACT_Y, tgme_pkg::REQ_IMPLANT_Y: begin
        range_err = (xs >= cols) || (ysum > rows);
        kind      = tgme_pkg::K_COLUMN;
      end
      tgme_pkg::REQ_LOAD: begin
        range_err = (xs >= cols);
        kind      = tgme_pkg::K_COLUMN;
      end
      tgme_pkg::REQ_CLEAR: begin
        range_err = 1'b0;
        kind      = tgme_pkg::K_NONE;
      end
      default: begin
        range_err = 1'b1;
        kind      = tgme_pkg::K_NONE;
      end
    endcase
    if (range_err) begin
      kind = tgme_pkg::K_NONE;
    end
  end

  assign stat.kind       = kind;
  assign stat.shift_done = (rem == '0);
  assign stat.xrun_last  = (rem == IW'(1));

  // Per-row masks; each bit is independent of the others.
  always_comb begin
    for (int r = 0; r < MAX_ROWS; r++) begin
      rm[r]    = (IW'(r) < rows);
      ymask[r] = (IW'(r) >= ys) && (IW'(r) < ysum);
    end
  end

  assign lb      = MAX_ROWS'(bits_r);
  assign up      = (req_r == tgme_pkg::REQ_UP);
  assign xset    = (req_r == tgme_pkg::REQ_EXTRACT_X);
  assign yset    = (req_r == tgme_pkg::REQ_EXTRACT_Y);
  assign pd      = up ? (p + IW'(1)) : (p - IW'(1));
  assign s_idx   = p[RW-1:0];
  assign d_idx   = pd[RW-1:0];
  assign y_idx   = ys[RW-1:0];
  assign yhit    = ymask & wa;
  assign occ_in  = (wa & ~rm) | (lb & rm);
  assign mark_in = (req_r == tgme_pkg::REQ_LOAD) ? (ma & ~rm)
                 : (yset ? (ma | yhit) : (ma & ~yhit));

  // Working column after one shift step; the atom carries its mark along.
  always_comb begin
    wa_mv        = wa;
    ma_mv        = ma;
    wa_mv[s_idx] = 1'b0;
    ma_mv[s_idx] = 1'b0;
    wa_mv[d_idx] = 1'b1;
    ma_mv[d_idx] = ma[d_idx] | ma[s_idx];
  end

  // Column memories with one write and one registered read per cycle.
  assign cur_addr  = cx[AW-1:0];
  assign next_addr = xs1[AW-1:0];
  assign req_addr  = xs[AW-1:0];
  assign mem_we    = cmd.wr_a || cmd.wr_b;
  assign wad       = cmd.wr_b ? next_addr : cur_addr;
  assign wd_occ    = cmd.wr_b ? wb : wa;
  assign wd_mark   = cmd.wr_b ? mb : ma;

  always_comb begin
    case (cmd.rd_sel)
      tgme_pkg::RD_CUR:  rad = cur_addr;
      tgme_pkg::RD_NEXT: rad = next_addr;
      tgme_pkg::RD_REQ:  rad = req_addr;
      default:           rad = req_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[wad]  <= wd_occ;
      mark_mem[wad] <= wd_mark;
    end
    if (cmd.rd_en) begin
      occ_rd  <= occ_mem[rad];
      mark_rd <= mark_mem[rad];
    end
  end

  // A column that was never written reads as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (mem_we) begin
        col_valid[wad] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid <= col_valid[rad];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (cmd.accept) begin
      if (req_type == tgme_pkg::REQ_CLEAR) begin
        counter <= '0;
      end else if (req_type <= tgme_pkg::REQ_IMPLANT_Y && counter != tgme_pkg::COUNT_MAX) begin
        counter <= counter + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r  <= req_type;
      x_r    <= x_pos;
      y_r    <= y_pos;
      len_r  <= run_length;
      bits_r <= load_bits;
    end
    if (cmd.init) begin
      cx       <= xs;
      p        <= up ? (ysum - IW'(1)) : (ys + IW'(1));
      rem      <= ls;
      status_r <= range_err ? tgme_pkg::ST_RANGE : tgme_pkg::ST_DONE;
    end
    if (cmd.next_col) begin
      cx  <= cx + IW'(1);
      rem <= rem - IW'(1);
    end
    if (cmd.load_a) begin
      wa <= rd_valid ? occ_rd : '0;
      ma <= rd_valid ? mark_rd : '0;
    end
    if (cmd.load_b) begin
      wb <= rd_valid ? occ_rd : '0;
      mb <= rd_valid ? mark_rd : '0;
    end
    if (cmd.step) begin
      case (kind)
        tgme_pkg::K_SHIFT: begin
          if (wa[s_idx] && wa[d_idx]) begin
            status_r <= tgme_pkg::ST_COLLISION;
            rem      <= '0;
          end else begin
            if (wa[s_idx]) begin
              wa <= wa_mv;
              ma <= ma_mv;
            end
            rem <= rem - IW'(1);
            p   <= up ? (p - IW'(1)) : (p + IW'(1));
          end
        end
        tgme_pkg::K_PAIR: begin
          if (wa[y_idx] && wb[y_idx]) begin
            status_r <= tgme_pkg::ST_COLLISION;
          end else if (req_r == tgme_pkg::REQ_RIGHT) begin
            if (wa[y_idx]) begin
              wa[y_idx] <= 1'b0;
              ma[y_idx] <= 1'b0;
              wb[y_idx] <= 1'b1;
              mb[y_idx] <= mb[y_idx] | ma[y_idx];
            end
          end else begin
            if (wb[y_idx]) begin
              wb[y_idx] <= 1'b0;
              mb[y_idx] <= 1'b0;
              wa[y_idx] <= 1'b1;
              ma[y_idx] <= ma[y_idx] | mb[y_idx];
            end
          end
        end
        tgme_pkg::K_COLUMN: begin
          if (req_r == tgme_pkg::REQ_LOAD) begin
            wa <= occ_in;
          end
          ma <= mark_in;
        end
        tgme_pkg::K_XRUN: begin
          if (wa[y_idx]) begin
            ma[y_idx] <= xset;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign x_in       = (xs < IW'(MAX_COLUMNS));
  assign col_masked = rd_valid ? occ_rd : '0;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status           <= status_r;
      column_occupancy <= x_in ? 32'(col_masked) : 32'd0;
      moves_done       <= counter;
    end
  end

endmodule

### hdl/trap_grid_move_engine.sv
// Trap grid move engine: a request starts when start is high while busy is low, and
// its result appears for exactly one cycle with done high; results cannot be held off,
// so the receiver must take them as they come. A count clear, an out-of-range or unknown
// request or an empty x-run does no column work; a y-run or column load works on its
// column, a right or left move on a column pair, an up or down shift walks its run (and
// stops early at a collision) and an x-run works on one column after another. Busy time
// comes from the column memory with its registered read, one read-modify-write per column,
// and the shift walk that moves one trap per cycle. A new request is taken in the cycle
// that done is high.
// Depends on tgme_pkg, tgme_regs, tgme_ctrl and tgme_dp.
module trap_grid_move_engine #(
  parameter int MAX_COLUMNS = tgme_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tgme_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  req_type,
  input  logic [4:0]                  x_pos,
  input  logic [4:0]                  y_pos,
  input  logic [5:0]                  run_length,
  input  logic [31:0]                 load_bits,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [31:0]                 column_occupancy,
  output logic [15:0]                 moves_done,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tgme_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [tgme_pkg::CFG_W-1:0] grid_columns;
  logic [tgme_pkg::CFG_W-1:0] grid_rows;
  tgme_pkg::cmd_t             cmd;
  tgme_pkg::stat_t            stat;

  tgme_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .grid_columns (grid_columns),
    .grid_rows    (grid_rows)
  );

  tgme_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  tgme_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .grid_columns     (grid_columns),
    .grid_rows        (grid_rows),
    .req_type         (req_type),
    .x_pos            (x_pos),
    .y_pos            (y_pos),
    .run_length       (run_length),
    .load_bits        (load_bits),
    .status           (status),
    .column_occupancy (column_occupancy),
    .moves_done       (moves_done)
  );

endmodule
